// ===== rtl/pps_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int TIME_W    = 16;
    localparam int WORK_W    = 16;
    localparam int PRIO_W    = 8;
    localparam int CFG_W     = 5;
    localparam int ENTRY_W   = TIME_W + PRIO_W + WORK_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [3:0]        slot;
        logic [15:0]       arrival_time;
        logic [15:0]       burst_length;
        logic [7:0]        priority_level;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        running_slot;
        logic              idle;
        logic              finished;
        logic [15:0]       tick_time;
    } t_out_item;

    // one slot as kept in the table memory
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [PRIO_W-1:0] prio;
        logic [WORK_W-1:0] work;
    } t_entry;

    typedef struct packed {
        logic              load_we;
        logic              scan_clear;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              commit;
    } t_dp_cmd;

    typedef struct packed {
        logic              out_free;
    } t_dp_sts;

endpackage

// ===== rtl/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pps_ctrl.sv =====
// Scheduler controller: accepts beats, sequences the slot scan and the commit.
module pps_ctrl
    import pps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_stall,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CFG_W-1:0] r_slots;
    logic [CNT_W-1:0] count;
    logic             accept;
    logic             last;

    // counts above the table size act as the table size
    assign count = (r_slots > CFG_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_slots);

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign last       = (r_idx == count - CNT_W'(1));

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        o_cmd            = '0;
        o_cmd.rd_addr    = r_idx[SLOT_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.scan_clear = 1'b1;
                        n_state = (count == '0) ? S_COMMIT : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_idx = r_idx + CNT_W'(1);
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_slots <= CFG_W'(16);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_slots <= i_cfg_wdata;
            end
        end
    end

    // a tick with slots in use starts the scan at slot zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_op == OP_TICK && count != '0) |=> (o_cmd.rd_en && o_cmd.rd_addr == '0))
        else $error("scan did not start at slot zero");

    // a commit always returns the controller to idle
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_IDLE))
        else $error("controller not idle after commit");

    // a load never overlaps a commit write
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_we && o_cmd.commit))
        else $error("load and commit in the same cycle");

endmodule

// ===== rtl/pps_dp.sv =====
// Scheduler datapath: slot table, best-candidate compare, time and result register.
module pps_dp
    import pps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_data,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_entry            rd_entry;
    t_entry            wr_entry;
    logic              we;
    logic [SLOT_W-1:0] waddr;

    logic              r_rd_vld;
    logic [SLOT_W-1:0] r_rd_idx;
    logic              r_found;
    logic [SLOT_W-1:0] r_best_idx;
    logic [TIME_W-1:0] r_best_arr;
    logic [PRIO_W-1:0] r_best_pri;
    logic [WORK_W-1:0] r_best_work;
    logic [TIME_W-1:0] r_time;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              eligible;
    logic              better;
    logic [WORK_W-1:0] new_work;

    assign new_work = r_best_work - WORK_W'(1);

    always_comb begin
        if (i_cmd.commit) begin
            we             = r_found;
            waddr          = r_best_idx;
            wr_entry.arrival = r_best_arr;
            wr_entry.prio    = r_best_pri;
            wr_entry.work    = new_work;
        end else begin
            we             = i_cmd.load_we;
            waddr          = i_in_data.slot[SLOT_W-1:0];
            wr_entry.arrival = TIME_W'(i_in_data.arrival_time);
            wr_entry.prio    = i_in_data.priority_level;
            wr_entry.work    = i_in_data.burst_length;
        end
    end

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rd_entry)
    );

    assign eligible = (rd_entry.arrival <= r_time) && (rd_entry.work != '0);
    // strict compares keep the earlier arrival, then the lower slot
    assign better   = !r_found || (rd_entry.prio < r_best_pri) ||
                      ((rd_entry.prio == r_best_pri) && (rd_entry.arrival < r_best_arr));

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.scan_clear) begin
                r_found <= 1'b0;
            end else if (r_rd_vld && eligible && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_time      <= r_time + TIME_W'(1);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.rd_addr;
        if (r_rd_vld && eligible && better) begin
            r_best_idx  <= r_rd_idx;
            r_best_arr  <= rd_entry.arrival;
            r_best_pri  <= rd_entry.prio;
            r_best_work <= rd_entry.work;
        end
        if (i_cmd.commit) begin
            r_out.running_slot <= r_found ? 4'(r_best_idx) : 4'd0;
            r_out.idle         <= !r_found;
            r_out.finished     <= r_found && (new_work == '0);
            r_out.tick_time    <= 16'(r_time);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // time moves by exactly one per committed tick
    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_time == TIME_W'($past(r_time) + 1'b1)))
        else $error("time did not advance on commit");

    // a result only appears after a commit
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("result without commit");

    // a pending result is never overwritten while stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("commit into a stalled result register");

endmodule

// ===== rtl/preemptive_priority_scheduler_core.sv =====
// Top level of the preemptive priority scheduler.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_stall   t_in_item  (load or tick)
//   out       output     o_out_valid / i_out_stall t_out_item (one per tick)
//   cfg       input      i_cfg_we                  slots_in_use, 5 bits
//
// A load beat writes the slot table in the accept cycle.
// A tick beat scans N = min(slots_in_use, 16) slots: one table read per
// slot through the single read port of the table memory, then a compare
// drain state and a commit state (straight to commit when N is zero).
// Reset clears time to zero and slots_in_use to 16; the slot table is not cleared.
// A stalled result holds the commit cycle until the result register frees.
module preemptive_priority_scheduler_core
    import pps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_data.operation),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
